// File: rtl/core/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared types, codes and constants of the disk host port protocol block.
// ----------------------------------------------------------------------------
package dhp_pkg;

  localparam int unsigned MEDIA_SECTORS = 4096;
  localparam int unsigned SECTOR_BYTES  = 512;
  localparam int unsigned OFF_W         = $clog2(SECTOR_BYTES);
  localparam int unsigned MEDIA_AW      = 21;
  localparam int unsigned MEDIA_BYTES   = MEDIA_SECTORS * SECTOR_BYTES;
  localparam int unsigned USED_W        = $clog2(MEDIA_SECTORS + 1);
  localparam int unsigned LBA_W         = 25;
  localparam int unsigned STREAM_W      = 18;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  // opcodes
  localparam logic [7:0] OP_READ_A    = 8'h08;
  localparam logic [7:0] OP_READ_B    = 8'hE5;
  localparam logic [7:0] OP_WRITE_A   = 8'h0A;
  localparam logic [7:0] OP_WRITE_B   = 8'hE6;
  localparam logic [7:0] OP_INIT      = 8'h0C;
  localparam logic [7:0] OP_DISCARD   = 8'h0F;

  // status codes
  localparam logic [7:0] ST_IDLE      = 8'h00;
  localparam logic [7:0] ST_REQ_FRAME = 8'h0D;
  localparam logic [7:0] ST_XFER_IN   = 8'h09;
  localparam logic [7:0] ST_RES0      = 8'h0F;
  localparam logic [7:0] ST_RES1      = 8'h1F;
  localparam logic [7:0] ST_XFER_OUT  = 8'h0B;
  localparam logic [7:0] NO_DATA      = 8'hFF;
  localparam logic [3:0] INIT_PARAMS  = 4'd8;

  typedef enum logic [2:0] {
    KIND_DATA_WR   = 3'd0,
    KIND_DATA_RD   = 3'd1,
    KIND_STATUS_WR = 3'd2,
    KIND_STATUS_RD = 3'd3,
    KIND_STROBE_WR = 3'd4,
    KIND_PRELOAD   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CMD_DATA_WR,
    CMD_DATA_RD,
    CMD_STATUS_WR,
    CMD_STATUS_RD,
    CMD_STROBE,
    CMD_PRELOAD,
    CMD_NONE
  } cmd_e;

  typedef enum logic [3:0] {
    P_PREFIX,
    P_STROBE,
    P_FRAME_REQ,
    P_FRAME_RX,
    P_PARAMS,
    P_RESULT0,
    P_RESULT1,
    P_RD_STREAM,
    P_WR_STREAM,
    P_DISCARD
  } phase_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [7:0]            data;
    logic [MEDIA_AW-1:0]   addr;
  } item_t;

  // boot signature of an empty first sector
  function automatic logic [7:0] boot_byte(input logic [OFF_W-1:0] off);
    logic [7:0] b;
    case (off)
      9'd0:    b = 8'hE9;
      9'd3:    b = 8'h45;
      9'd4:    b = 8'h50;
      9'd5:    b = 8'h53;
      9'd6:    b = 8'h4F;
      9'd7:    b = 8'h4E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/dhp_front.sv
// ----------------------------------------------------------------------------
// dhp_front
// Accepts requests, classifies the kind and queues them for the engine.
// ----------------------------------------------------------------------------
module dhp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 kind_i,
  input  logic [7:0]                 data_i,
  input  logic [dhp_pkg::MEDIA_AW-1:0] media_address_i,
  output logic                       q_valid_o,
  output dhp_pkg::item_t             q_item_o,
  input  logic                       q_pop_i
);
  import dhp_pkg::*;

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  item_t             item_in;
  logic              push;

  // classify the request kind
  always_comb begin
    item_in.data = data_i;
    item_in.addr = media_address_i;
    case (kind_e'(kind_i))
      KIND_DATA_WR:   item_in.cmd = CMD_DATA_WR;
      KIND_DATA_RD:   item_in.cmd = CMD_DATA_RD;
      KIND_STATUS_WR: item_in.cmd = CMD_STATUS_WR;
      KIND_STATUS_RD: item_in.cmd = CMD_STATUS_RD;
      KIND_STROBE_WR: item_in.cmd = CMD_STROBE;
      KIND_PRELOAD:   item_in.cmd = CMD_PRELOAD;
      default:        item_in.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (q_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop_i);
    end
  end

endmodule

// File: rtl/core/dhp_engine.sv
// ----------------------------------------------------------------------------
// dhp_engine
// Protocol engine: phase tracking, frame decode, streams and media memory.
// ----------------------------------------------------------------------------
module dhp_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  dhp_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     read_data_o
);
  import dhp_pkg::*;

  phase_e                phase_q, phase_d, after_q, after_d;
  logic                  probe_q, probe_d, armed_q, armed_d, ack_q, ack_d;
  logic [7:0]            prefix_q, prefix_d, opcode_q, opcode_d;
  logic [2:0]            fpos_q, fpos_d;
  logic [7:0]            fb_q [6];
  logic [7:0]            fb_n [6];
  logic [2:0]            fb_idx;
  logic [23:0]           sector_q, sector_d;
  logic [8:0]            count_q, count_d;
  logic                  result_q, result_d;
  logic [3:0]            params_q, params_d;
  logic [STREAM_W-1:0]   total_q, total_d, spos_q, spos_d, spos_inc;
  logic [USED_W-1:0]     used_q, used_d;
  logic                  busy_q, busy_d, use_mem_q, use_mem_d;
  logic [7:0]            const_q, const_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_data_q, out_data_d;
  logic                  accept, more, fb_we;
  logic [LBA_W-1:0]      lba;
  logic [OFF_W-1:0]      off;
  logic                  lba_used, lba_in_media;
  logic                  mem_we, mem_re;
  logic [MEDIA_AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata, mem_rdata_q;
  logic [7:0]            media [MEDIA_BYTES];

  assign accept       = q_valid_i && !busy_q && (!out_valid_q || out_ready_i);
  assign q_pop_o      = accept;
  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign more         = (spos_q < total_q);
  assign spos_inc     = spos_q + 1'b1;
  assign lba          = {1'b0, sector_q} + LBA_W'(spos_q[STREAM_W-1:OFF_W]);
  assign off          = spos_q[OFF_W-1:0];
  assign lba_in_media = (lba < LBA_W'(MEDIA_SECTORS));
  assign lba_used     = lba_in_media && (lba < LBA_W'(used_q));
  assign mem_raddr    = MEDIA_AW'({lba, off});

  // frame byte capture with the incoming byte merged in
  always_comb begin
    fb_n   = fb_q;
    fb_idx = (phase_q == P_FRAME_REQ) ? 3'd0 : fpos_q;
    fb_we  = accept && q_item_i.cmd == CMD_DATA_WR
             && (phase_q == P_FRAME_REQ || (phase_q == P_FRAME_RX && fpos_q < 3'd6));
    if (fb_we) fb_n[fb_idx] = q_item_i.data;
  end

  // protocol next state
  always_comb begin
    phase_d = phase_q; after_d = after_q; probe_d = probe_q; armed_d = armed_q;
    ack_d = ack_q; prefix_d = prefix_q; opcode_d = opcode_q; fpos_d = fpos_q;
    sector_d = sector_q; count_d = count_q; result_d = result_q;
    params_d = params_q; total_d = total_q; spos_d = spos_q; used_d = used_q;
    busy_d = 1'b0; use_mem_d = use_mem_q; const_d = const_q;
    out_valid_d = out_valid_q && !out_ready_i; out_data_d = out_data_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_waddr = q_item_i.addr;
    mem_wdata = q_item_i.data;

    // finish a media read request
    if (busy_q) begin
      out_valid_d = 1'b1;
      out_data_d  = use_mem_q ? mem_rdata_q : const_q;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = 8'h00;
      case (q_item_i.cmd)
        CMD_DATA_WR: begin
          case (phase_q)
            P_PREFIX: begin
              prefix_d = q_item_i.data;
              armed_d  = 1'b1;
              phase_d  = P_STROBE;
            end
            P_FRAME_REQ: begin
              fpos_d  = 3'd1;
              phase_d = P_FRAME_RX;
            end
            P_FRAME_RX: begin
              if (fb_we) fpos_d = fpos_q + 1'b1;
              if (fpos_d == 3'd6) begin
                opcode_d = fb_n[0];
                sector_d = {fb_n[1], fb_n[2], fb_n[3]};
                count_d  = (fb_n[4] == 8'h00) ? 9'd256 : {1'b0, fb_n[4]};
                total_d  = '0;
                spos_d   = '0;
                result_d = 1'b0;
                after_d  = P_RESULT0;
                ack_d    = 1'b1;
                case (fb_n[0])
                  OP_READ_A, OP_READ_B: begin
                    total_d = {count_d, {OFF_W{1'b0}}};
                    after_d = P_RD_STREAM;
                  end
                  OP_WRITE_A, OP_WRITE_B: begin
                    total_d = {count_d, {OFF_W{1'b0}}};
                    after_d = P_WR_STREAM;
                  end
                  OP_INIT: begin
                    params_d = INIT_PARAMS;
                    after_d  = P_PARAMS;
                  end
                  OP_DISCARD: begin
                    total_d = {count_d, {OFF_W{1'b0}}};
                    after_d = P_DISCARD;
                  end
                  default: result_d = 1'b1;
                endcase
              end
            end
            P_PARAMS: begin
              if (params_q != '0) params_d = params_q - 1'b1;
              if (params_d == '0) phase_d = P_RESULT0;
            end
            P_WR_STREAM, P_DISCARD: begin
              if (more) begin
                spos_d = spos_inc;
                if (phase_q == P_WR_STREAM && lba_in_media) begin
                  mem_we    = 1'b1;
                  mem_waddr = mem_raddr;
                  if (lba + 1'b1 > LBA_W'(used_q)) used_d = USED_W'(lba + 1'b1);
                end
                if (spos_inc >= total_q) begin
                  total_d = '0;
                  spos_d  = '0;
                  phase_d = P_RESULT0;
                end
              end
            end
            default: ;
          endcase
        end
        CMD_DATA_RD: begin
          out_data_d = NO_DATA;
          case (phase_q)
            P_RESULT0: begin
              out_data_d = {7'd0, result_q};
              phase_d    = P_RESULT1;
            end
            P_RESULT1: begin
              out_data_d = 8'h00;
              phase_d = P_PREFIX; armed_d = 1'b0; prefix_d = '0;
              fpos_d = '0; ack_d = 1'b0; after_d = P_RESULT0; params_d = '0;
              total_d = '0; spos_d = '0;
            end
            P_RD_STREAM: begin
              out_data_d = 8'h00;
              if (more) begin
                // media byte comes through the registered read port
                out_valid_d = 1'b0;
                busy_d      = 1'b1;
                mem_re      = 1'b1;
                use_mem_d   = lba_used;
                const_d     = (lba == '0) ? boot_byte(off) : 8'h00;
                spos_d      = spos_inc;
                if (spos_inc >= total_q) begin
                  total_d = '0; spos_d = '0; phase_d = P_RESULT0;
                end
              end else begin
                total_d = '0; spos_d = '0; phase_d = P_RESULT0;
              end
            end
            default: ;
          endcase
        end
        CMD_STATUS_WR: begin
          phase_d = P_PREFIX; armed_d = 1'b0; prefix_d = '0;
          fpos_d = '0; ack_d = 1'b0; after_d = P_RESULT0; params_d = '0;
          total_d = '0; spos_d = '0; probe_d = 1'b1;
        end
        CMD_STATUS_RD: begin
          if (probe_q) begin
            probe_d = 1'b0;
          end else if (phase_q == P_PREFIX || phase_q == P_STROBE) begin
            out_data_d = ST_IDLE;
          end else if (ack_q) begin
            ack_d   = 1'b0;
            phase_d = after_q;
          end else begin
            case (phase_q)
              P_FRAME_REQ:  out_data_d = ST_REQ_FRAME;
              P_PARAMS:     out_data_d = ST_XFER_IN;
              P_RESULT0:    out_data_d = ST_RES0;
              P_RESULT1:    out_data_d = ST_RES1;
              P_RD_STREAM:  out_data_d = more ? ST_XFER_OUT : ST_IDLE;
              P_WR_STREAM, P_DISCARD:
                            out_data_d = more ? ST_XFER_IN : ST_IDLE;
              default:      out_data_d = ST_IDLE;
            endcase
          end
        end
        CMD_STROBE: begin
          if (phase_q == P_STROBE && armed_q && q_item_i.data == prefix_q) begin
            fpos_d = '0; ack_d = 1'b0; after_d = P_RESULT0; params_d = '0;
            total_d = '0; spos_d = '0; armed_d = 1'b1; phase_d = P_FRAME_REQ;
          end
        end
        CMD_PRELOAD: begin
          if ({1'b0, q_item_i.addr} < (MEDIA_AW+1)'(MEDIA_BYTES)) begin
            mem_we = 1'b1;
            if ((USED_W+1)'(q_item_i.addr[MEDIA_AW-1:OFF_W]) + 1'b1
                > (USED_W+1)'(used_q)) begin
              used_d = USED_W'(q_item_i.addr[MEDIA_AW-1:OFF_W]) + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // media memory
  always_ff @(posedge clk_i) begin
    if (mem_we) media[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= media[mem_raddr];
  end

  // frame bytes and read path payload
  always_ff @(posedge clk_i) begin
    fb_q       <= fb_n;
    use_mem_q  <= use_mem_d;
    const_q    <= const_d;
    out_data_q <= out_data_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_PREFIX; after_q <= P_RESULT0; probe_q <= 1'b0;
      armed_q <= 1'b0; ack_q <= 1'b0; prefix_q <= '0; opcode_q <= '0;
      fpos_q <= '0; sector_q <= '0; count_q <= '0; result_q <= 1'b0;
      params_q <= '0; total_q <= '0; spos_q <= '0; used_q <= '0;
      busy_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; after_q <= after_d; probe_q <= probe_d;
      armed_q <= armed_d; ack_q <= ack_d; prefix_q <= prefix_d;
      opcode_q <= opcode_d; fpos_q <= fpos_d; sector_q <= sector_d;
      count_q <= count_d; result_q <= result_d; params_q <= params_d;
      total_q <= total_d; spos_q <= spos_d; used_q <= used_d;
      busy_q <= busy_d; out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/disk_host_port_protocol_top.sv
// ----------------------------------------------------------------------------
// disk_host_port_protocol_top
// Disk host interface: data, status and strobe ports over a media store.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i in_ready_o kind_i data_i       | request in
//          | media_address_i                           |
//  out     | out_valid_o out_ready_i read_data_o       | one result per request
//
// A data read from the media stream returns its byte through the registered
// read port of the media memory; no new request is taken while it is pending.
// A four-entry queue sits between the front and the engine, so requests keep
// flowing while a result waits at the output register.
// Reset is asynchronous and clears only control state; the media store holds
// whatever was written and needs no clearing pass.
module disk_host_port_protocol_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   kind_i,
  input  logic [7:0]                   data_i,
  input  logic [dhp_pkg::MEDIA_AW-1:0] media_address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   read_data_o
);
  import dhp_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  // front: accept and classify
  dhp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .data_i,
    .media_address_i, .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // back: protocol engine
  dhp_engine u_engine (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .read_data_o
  );

endmodule
